@@ rtl/ccc_pkg.sv @@
// shared types, constants and calendar helper functions for the calendar clock counter
// no dependencies; imported by every module of the block
package ccc_pkg;

	localparam logic [5:0]  SEC_LAST   = 6'd59;
	localparam logic [5:0]  MIN_LAST   = 6'd59;
	localparam logic [4:0]  HOUR_LAST  = 5'd23;
	localparam logic [3:0]  MONTH_LAST = 4'd12;
	localparam logic [13:0] YEAR_LAST  = 14'd9999;
	localparam logic [6:0]  REM_LAST   = 7'd99;
	localparam logic [13:0] YEAR_RESET = 14'd2000;
	// year / 100 as (year * CENT_RECIP) >> CENT_SHIFT, exact for every 14-bit year
	localparam logic [12:0] CENT_RECIP = 13'd5243;
	localparam int          CENT_SHIFT = 19;

	localparam logic [0:0]  CMD_TICK = 1'b0;
	localparam logic [0:0]  CMD_SET  = 1'b1;

	// one input word as held in the input register, plus its century count
	typedef struct packed {
		logic [0:0]  command;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [13:0] year;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [7:0]  cent;
	} ccc_item_t;

	// leap rule from year mod 100 and century mod 4
	function automatic logic leap_of(input logic [6:0] rem, input logic [1:0] cent4);
		logic leap;
		if (rem == 7'd0) begin
			leap = (cent4 == 2'd0);
		end else begin
			leap = (rem[1:0] == 2'd0);
		end
		return leap;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

@@ rtl/ccc_in_stage.sv @@
// input register of the calendar clock counter with the century reciprocal multiply
// depends on ccc_pkg
module ccc_in_stage import ccc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  ccc_item_t item,
	input  logic      drain,
	output logic      s1_valid,
	output ccc_item_t s1_item
);

	logic [26:0] cent_prod;
	logic        load;
	ccc_item_t   item_c;

	assign cent_prod = item.year * CENT_RECIP;
	assign load      = take;

	// incoming word with its century count filled in
	always_comb begin
		item_c      = item;
		item_c.cent = cent_prod[CENT_SHIFT+7:CENT_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (load) begin
			s1_valid <= 1'b1;
		end else if (drain) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			s1_item <= item_c;
		end
	end

endmodule

@@ rtl/ccc_core.sv @@
// calendar counters, tick carry and set validation logic, result register
// depends on ccc_pkg
module ccc_core import ccc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s1_valid,
	input  ccc_item_t  s1_item,
	input  logic       result_stall,
	output logic       advance,
	output logic       result_valid,
	output logic [5:0] cur_second,
	output logic [5:0] cur_minute,
	output logic [4:0] cur_hour,
	output logic [4:0] cur_day,
	output logic [3:0] cur_month,
	output logic [13:0] cur_year,
	output logic [3:0] hour_twelve,
	output logic       is_pm
);

	logic [6:0]  rem_q;
	logic [1:0]  cent4_q;

	logic [5:0]  sec_d, min_d;
	logic [4:0]  hour_d, day_d, mlen;
	logic [3:0]  month_d, h12_d;
	logic [13:0] year_d, cent_x100, rem_full;
	logic [6:0]  rem_d, set_rem;
	logic [1:0]  cent4_d, set_cent4;
	logic        leap_cur, set_leap, pm_d;

	assign advance  = s1_valid && (!result_valid || !result_stall);
	assign leap_cur = leap_of(rem_q, cent4_q);

	assign cent_x100 = {s1_item.cent, 6'b0} + {1'b0, s1_item.cent, 5'b0}
		+ {4'b0, s1_item.cent, 2'b0};
	assign rem_full  = s1_item.year - cent_x100;

	always_comb begin
		sec_d   = cur_second;
		min_d   = cur_minute;
		hour_d  = cur_hour;
		day_d   = cur_day;
		month_d = cur_month;
		year_d  = cur_year;
		rem_d   = rem_q;
		cent4_d = cent4_q;
		mlen    = month_len(cur_month, leap_cur);
		set_rem   = rem_full[6:0];
		set_cent4 = s1_item.cent[1:0];
		set_leap  = 1'b0;
		if (s1_item.command == CMD_SET) begin
			month_d = (s1_item.month >= 7'd1 && s1_item.month <= {3'b0, MONTH_LAST})
				? s1_item.month[3:0] : 4'd1;
			if (s1_item.year > YEAR_LAST) begin
				set_rem   = 7'd0;
				set_cent4 = 2'd0;
				year_d    = 14'd0;
			end else begin
				year_d = s1_item.year;
			end
			rem_d    = set_rem;
			cent4_d  = set_cent4;
			set_leap = leap_of(set_rem, set_cent4);
			mlen     = month_len(month_d, set_leap);
			day_d    = (s1_item.day >= 7'd1 && s1_item.day <= {2'b0, mlen})
				? s1_item.day[4:0] : 5'd1;
			hour_d   = (s1_item.hour <= {2'b0, HOUR_LAST}) ? s1_item.hour[4:0] : 5'd0;
			min_d    = (s1_item.minute <= {1'b0, MIN_LAST}) ? s1_item.minute[5:0] : 6'd0;
			sec_d    = (s1_item.second <= {1'b0, SEC_LAST}) ? s1_item.second[5:0] : 6'd0;
		end else if (cur_second != SEC_LAST) begin
			sec_d = cur_second + 6'd1;
		end else begin
			sec_d = 6'd0;
			if (cur_minute != MIN_LAST) begin
				min_d = cur_minute + 6'd1;
			end else begin
				min_d = 6'd0;
				if (cur_hour != HOUR_LAST) begin
					hour_d = cur_hour + 5'd1;
				end else begin
					hour_d = 5'd0;
					if (cur_day < mlen) begin
						day_d = cur_day + 5'd1;
					end else begin
						day_d = 5'd1;
						if (cur_month < MONTH_LAST) begin
							month_d = cur_month + 4'd1;
						end else begin
							month_d = 4'd1;
							// 9999 wraps to 0: remainder and century mod 4 wrap too
							year_d = (cur_year >= YEAR_LAST) ? 14'd0 : cur_year + 14'd1;
							if (rem_q == REM_LAST) begin
								rem_d   = 7'd0;
								cent4_d = cent4_q + 2'd1;
							end else begin
								rem_d = rem_q + 7'd1;
							end
						end
					end
				end
			end
		end
		pm_d = (hour_d >= 5'd12);
		if (hour_d == 5'd0 || hour_d == 5'd12) begin
			h12_d = 4'd12;
		end else if (pm_d) begin
			h12_d = 4'(hour_d - 5'd12);
		end else begin
			h12_d = hour_d[3:0];
		end
	end

	// counters double as the result register: they only move when the result is replaced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			cur_second   <= 6'd0;
			cur_minute   <= 6'd0;
			cur_hour     <= 5'd0;
			cur_day      <= 5'd1;
			cur_month    <= 4'd1;
			cur_year     <= YEAR_RESET;
			rem_q        <= 7'd0;
			cent4_q      <= 2'd0;
			hour_twelve  <= 4'd12;
			is_pm        <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
			cur_second   <= sec_d;
			cur_minute   <= min_d;
			cur_hour     <= hour_d;
			cur_day      <= day_d;
			cur_month    <= month_d;
			cur_year     <= year_d;
			rem_q        <= rem_d;
			cent4_q      <= cent4_d;
			hour_twelve  <= h12_d;
			is_pm        <= pm_d;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

endmodule

@@ rtl/calendar_clock_counter_unit.sv @@
// top level of the calendar clock counter: input register stage and counter core
// depends on ccc_pkg, ccc_in_stage and ccc_core
// - input channel: item_valid / item_stall with command and the set_* fields; a word is
//   taken at a rising edge with item_valid high and item_stall low
// - command tick advances the second with carries through minute, hour, day, month and
//   year (gregorian leap rule, year 9999 wraps to 0); command set loads all six fields,
//   out-of-range values replaced by their defaults and the day checked against the
//   loaded month and year
// - result channel: result_valid / result_stall, one result word per input word with
//   the date and time after the step, plus 12-hour hour and pm flag
// - path: a word taken into the input register updates the counters, which are the result
//   register, as soon as the result register can take a new result
// - throughput: one word per cycle while the result is not stalled; the whole carry chain
//   and set check are combinational between the input register and the counters
// - the leap test runs on a kept year mod 100 and century mod 4; the century count
//   of a set comes from a reciprocal multiply ahead of the input register
// - stall: while result_stall holds a waiting result, one more word is taken into the
//   input register, then item_stall rises until the result is taken
// - reset: asynchronous, active low; clears both valids and sets the clock to
//   00:00:00 on january 1st 2000
module calendar_clock_counter_unit import ccc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [0:0]  command,
	input  logic [6:0]  set_month,
	input  logic [6:0]  set_day,
	input  logic [13:0] set_year,
	input  logic [6:0]  set_hour,
	input  logic [6:0]  set_minute,
	input  logic [6:0]  set_second,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [5:0]  cur_second,
	output logic [5:0]  cur_minute,
	output logic [4:0]  cur_hour,
	output logic [4:0]  cur_day,
	output logic [3:0]  cur_month,
	output logic [13:0] cur_year,
	output logic [3:0]  hour_twelve,
	output logic        is_pm
);

	ccc_item_t item;
	ccc_item_t s1_item;
	logic      s1_valid;
	logic      advance;
	logic      take;

	// input word as a struct; the century count is filled in by the input stage
	assign item = '{command: command, month: set_month, day: set_day, year: set_year,
		hour: set_hour, minute: set_minute, second: set_second, cent: 8'd0};

	// input register frees up in the same cycle its word moves into the counters
	assign item_stall = s1_valid && !advance;
	assign take       = item_valid && !item_stall;

	ccc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.drain    (advance),
		.s1_valid (s1_valid),
		.s1_item  (s1_item)
	);

	ccc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (s1_valid),
		.s1_item      (s1_item),
		.result_stall (result_stall),
		.advance      (advance),
		.result_valid (result_valid),
		.cur_second   (cur_second),
		.cur_minute   (cur_minute),
		.cur_hour     (cur_hour),
		.cur_day      (cur_day),
		.cur_month    (cur_month),
		.cur_year     (cur_year),
		.hour_twelve  (hour_twelve),
		.is_pm        (is_pm)
	);

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for calendar_clock_counter_unit: directed edges, then random words
// depends on ccc_pkg (command codes, counter limits, reset year) and the rtl of the block
module testbench import ccc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_WORDS     = 475;
	localparam int DRAIN_CYCLES    = 8;

	// one input word as driven on the ports
	typedef struct packed {
		logic [0:0]  command;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [13:0] year;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} clock_word_t;

	// one result word: the date and time after the step
	typedef struct packed {
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [3:0]  hour_twelve;
		logic        is_pm;
	} readout_t;

	// gregorian rule: every 400th year leap, other centuries not, else every 4th
	function automatic logic leap_year_of(logic [13:0] y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic logic [4:0] days_in_month(logic [3:0] m, logic [13:0] y);
		unique case (m)
			4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
			4'd2:                    return leap_year_of(y) ? 5'd29 : 5'd28;
			default:                 return 5'd31;
		endcase
	endfunction

	// keeps its own copy of the clock and the readouts still owed by the block
	class calendar_checker;
		logic [5:0]  sec_now;
		logic [5:0]  minute_now;
		logic [4:0]  hour_now;
		logic [4:0]  day_now;
		logic [3:0]  month_now;
		logic [13:0] year_now;
		readout_t    pending_readouts[$];
		int          failures;

		function new();
			sec_now    = '0;
			minute_now = '0;
			hour_now   = '0;
			day_now    = 5'd1;
			month_now  = 4'd1;
			year_now   = YEAR_RESET;
			failures   = 0;
		endfunction

		// advance or load the clock for an accepted word and queue the readout it owes
		function void note_word(clock_word_t w);
			readout_t r;
			if (w.command == CMD_SET) begin
				month_now  = (w.month >= 1 && w.month <= MONTH_LAST) ? w.month[3:0] : 4'd1;
				year_now   = (w.year <= YEAR_LAST) ? w.year : 14'd0;
				day_now    = (w.day >= 1 && w.day <= days_in_month(month_now, year_now)) ?
					w.day[4:0] : 5'd1;
				hour_now   = (w.hour <= HOUR_LAST) ? w.hour[4:0] : 5'd0;
				minute_now = (w.minute <= MIN_LAST) ? w.minute[5:0] : 6'd0;
				sec_now    = (w.second <= SEC_LAST) ? w.second[5:0] : 6'd0;
			end else if (sec_now < SEC_LAST) begin
				sec_now++;
			end else begin
				sec_now = '0;
				if (minute_now < MIN_LAST) begin
					minute_now++;
				end else begin
					minute_now = '0;
					if (hour_now < HOUR_LAST) begin
						hour_now++;
					end else begin
						hour_now = '0;
						if (day_now < days_in_month(month_now, year_now)) begin
							day_now++;
						end else begin
							day_now = 5'd1;
							if (month_now < MONTH_LAST) begin
								month_now++;
							end else begin
								month_now = 4'd1;
								year_now  = (year_now >= YEAR_LAST) ? 14'd0 : year_now + 14'd1;
							end
						end
					end
				end
			end
			r.second      = sec_now;
			r.minute      = minute_now;
			r.hour        = hour_now;
			r.day         = day_now;
			r.month       = month_now;
			r.year        = year_now;
			r.hour_twelve = (hour_now == 0 || hour_now == 12) ? 4'd12 : 4'(hour_now % 12);
			r.is_pm       = (hour_now >= 12);
			pending_readouts.push_back(r);
		endfunction

		function void compare_field(string label, int unsigned want_v, int unsigned got_v);
			if (want_v != got_v) begin
				$display("%0t: %s expected %0d, got %0d", $time, label, want_v, got_v);
				failures++;
			end
		endfunction

		function void check_readout(readout_t got);
			readout_t want;
			if (pending_readouts.size() == 0) begin
				$display("%0t: result word with no expectation waiting", $time);
				failures++;
				return;
			end
			want = pending_readouts.pop_front();
			compare_field("cur_second", want.second, got.second);
			compare_field("cur_minute", want.minute, got.minute);
			compare_field("cur_hour", want.hour, got.hour);
			compare_field("cur_day", want.day, got.day);
			compare_field("cur_month", want.month, got.month);
			compare_field("cur_year", want.year, got.year);
			compare_field("hour_twelve", want.hour_twelve, got.hour_twelve);
			compare_field("is_pm", want.is_pm, got.is_pm);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [0:0]  command;
	logic [6:0]  set_month;
	logic [6:0]  set_day;
	logic [13:0] set_year;
	logic [6:0]  set_hour;
	logic [6:0]  set_minute;
	logic [6:0]  set_second;
	logic        result_valid;
	logic        result_stall;
	logic [5:0]  cur_second;
	logic [5:0]  cur_minute;
	logic [4:0]  cur_hour;
	logic [4:0]  cur_day;
	logic [3:0]  cur_month;
	logic [13:0] cur_year;
	logic [3:0]  hour_twelve;
	logic        is_pm;

	calendar_checker chk = new();

	// idle odds per cycle in percent, changed between phases
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// set by the stimulus to ask the receiver for one long hold-off
	int hold_request  = 0;
	int words_sent    = 0;
	int idle_cycles   = 0;

	calendar_clock_counter_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.set_month    (set_month),
		.set_day      (set_day),
		.set_year     (set_year),
		.set_hour     (set_hour),
		.set_minute   (set_minute),
		.set_second   (set_second),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cur_second   (cur_second),
		.cur_minute   (cur_minute),
		.cur_hour     (cur_hour),
		.cur_day      (cur_day),
		.cur_month    (cur_month),
		.cur_year     (cur_year),
		.hour_twelve  (hour_twelve),
		.is_pm        (is_pm)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// monitor: both handshakes are sampled at the rising edge before any new drive lands;
	// the input word is noted first so the expectation always exists before its result
	always @(posedge clk) begin : monitor
		logic progress;
		progress = 1'b0;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				chk.note_word(clock_word_t'{command, set_month, set_day, set_year,
					set_hour, set_minute, set_second});
				progress = 1'b1;
			end
			if (result_valid && !result_stall) begin
				chk.check_readout(readout_t'{cur_second, cur_minute, cur_hour, cur_day,
					cur_month, cur_year, hour_twelve, is_pm});
				progress = 1'b1;
			end
		end
		// watchdog: too long without any word moving on either side
		idle_cycles = progress ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stall per cycle, or one long hold-off when asked for
	initial begin : receiver
		int hold_len;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_len     = hold_request;
				hold_request = 0;
				result_stall <= 1'b1;
				// counted here so the sender keeps offering words meanwhile
				repeat (hold_len) @(posedge clk);
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	function automatic clock_word_t set_word(int unsigned mo, int unsigned d, int unsigned y,
		int unsigned h, int unsigned mi, int unsigned s);
		clock_word_t w;
		w.command = CMD_SET;
		w.month   = 7'(mo);
		w.day     = 7'(d);
		w.year    = 14'(y);
		w.hour    = 7'(h);
		w.minute  = 7'(mi);
		w.second  = 7'(s);
		return w;
	endfunction

	// a tick carries random junk in the set fields, which the block must ignore
	function automatic clock_word_t tick_word();
		logic [63:0] junk;
		clock_word_t w;
		junk      = {$urandom, $urandom};
		w         = junk[$bits(clock_word_t)-1:0];
		w.command = CMD_TICK;
		return w;
	endfunction

	// offer one word until taken, then maybe leave the channel idle for a while
	task automatic send_word(clock_word_t w);
		item_valid <= 1'b1;
		command    <= w.command;
		set_month  <= w.month;
		set_day    <= w.day;
		set_year   <= w.year;
		set_hour   <= w.hour;
		set_minute <= w.minute;
		set_second <= w.second;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		words_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_word(tick_word());
	endtask

	// sender pause: nothing offered until every owed readout has come back
	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (chk.pending_readouts.size() != 0);
	endtask

	// one random scenario; most load a time just short of a rollover and tick across it
	task automatic run_scenario();
		int kind;
		int y;
		int m;
		int len;
		int d;
		kind = $urandom_range(99);
		if (kind < 55) begin
			case ($urandom_range(9))
				0:       y = 0;
				1:       y = 4;
				2:       y = 100;
				3:       y = 400;
				4:       y = 1900;
				5:       y = 2000;
				6:       y = 2100;
				7:       y = YEAR_LAST;
				8:       y = 9996;
				default: y = $urandom_range(YEAR_LAST);
			endcase
			if ($urandom_range(2) == 0) begin
				m = 2;
			end else begin
				m = ($urandom_range(1) == 0) ? MONTH_LAST : $urandom_range(1, 12);
			end
			len = days_in_month(4'(m), 14'(y));
			// now and then a day past the month end, which loads as the first
			if ($urandom_range(9) == 0) begin
				d = len + $urandom_range(1, 3);
			end else begin
				d = len - $urandom_range(0, 1);
			end
			send_word(set_word(m, d, y,
				($urandom_range(3) == 0) ? $urandom_range(23) : 23,
				($urandom_range(3) == 0) ? $urandom_range(59) : 59,
				$urandom_range(50, 59)));
			send_ticks(($urandom_range(4) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 12));
		end else if (kind < 70) begin
			send_ticks($urandom_range(1, 20));
		end else if (kind < 88) begin
			// full-width junk, mostly out of range
			send_word(set_word($urandom_range(127), $urandom_range(127), $urandom_range(16383),
				$urandom_range(127), $urandom_range(127), $urandom_range(127)));
			send_ticks($urandom_range(0, 3));
		end else begin
			m = $urandom_range(1, 12);
			y = $urandom_range(YEAR_LAST);
			d = $urandom_range(1, days_in_month(4'(m), 14'(y)));
			send_word(set_word(m, d, y, $urandom_range(23), $urandom_range(59),
				$urandom_range(59)));
			send_ticks($urandom_range(1, 5));
		end
	endtask

	initial begin : stimulus
		clock_word_t ones_tick;
		int target;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		command    <= CMD_TICK;
		set_month  <= '0;
		set_day    <= '0;
		set_year   <= '0;
		set_hour   <= '0;
		set_minute <= '0;
		set_second <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		send_word(tick_word());                         // first second after reset
		send_word(set_word(2, 28, 1900, 23, 59, 59));  // century year is not leap
		send_word(tick_word());
		send_word(set_word(2, 29, 2000, 23, 59, 59));  // every 400th year is leap
		send_word(tick_word());
		send_word(set_word(2, 28, 2024, 23, 59, 59));  // plain leap year, goes to the 29th
		send_word(tick_word());
		send_word(set_word(12, 31, YEAR_LAST, 23, 59, 59)); // year wraps to zero
		send_word(tick_word());
		send_word(set_word(2, 29, 0, 11, 59, 59));     // year zero is leap; noon turns pm
		send_word(tick_word());
		send_word(set_word(4, 30, 2023, 23, 59, 59));  // thirty-day month end
		send_word(tick_word());
		send_word(set_word(2, 29, 2023, 0, 59, 59));   // no 29th in a common february
		send_word(tick_word());
		send_word(set_word(127, 127, 16383, 127, 127, 127)); // every field at its top
		send_word(set_word(0, 0, 0, 0, 0, 0));          // every field at zero
		send_word(set_word(13, 31, 10000, 24, 60, 60)); // each field but the day one past its range
		send_word(set_word(6, 31, 2023, 23, 59, 58));  // 31st of june loads as the 1st
		send_word(tick_word());
		send_word(tick_word());
		send_word(set_word(12, 31, 2023, 23, 58, 59)); // minute carry only, hour holds
		send_word(tick_word());
		ones_tick         = '1;
		ones_tick.command = CMD_TICK;
		send_word(ones_tick);                           // tick with all set fields high
		send_word(tick_word());
		wait_drained();

		// sender idles more lightly than the receiver
		send_idle_pct = 33;
		recv_idle_pct = 45;
		target = words_sent + PHASE_WORDS;
		while (words_sent < target) run_scenario();
		wait_drained();

		// the other way round
		send_idle_pct = 45;
		recv_idle_pct = 33;
		target = words_sent + PHASE_WORDS;
		while (words_sent < target) run_scenario();
		wait_drained();

		// full rate, opened by a long receiver hold-off so the block backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request  = HOLD_OFF_CYCLES;
		target = words_sent + PHASE_WORDS;
		while (words_sent < target) run_scenario();
		wait_drained();

		// let the block run on idle to catch stray results
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (chk.failures == 0 && chk.pending_readouts.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/ccc_pkg.sv
rtl/ccc_in_stage.sv
rtl/ccc_core.sv
rtl/calendar_clock_counter_unit.sv
tb/testbench.sv
